>>> hw/rtl/dmfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults of the delimited message field parser.
// No dependencies; imported by dmfp_store, the top level and the testbench.
package dmfp_pkg;

   localparam int unsigned DefMaxItems     = 16;
   localparam int unsigned DefMaxItemChars = 32;

   localparam logic [7:0] StartCharReset = 8'd91;
   localparam logic [7:0] StopCharReset  = 8'd93;
   localparam logic [7:0] SepCharReset   = 8'd44;

   localparam logic [7:0] CharNewline = 8'd10;
   localparam logic [7:0] CharSpace   = 8'd32;
   localparam logic [7:0] CharNull    = 8'd0;

   typedef enum logic [1:0] {
      CSR_START = 2'd0,
      CSR_STOP  = 2'd1,
      CSR_SEP   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_RECV = 3'b010,
      MODE_DONE = 3'b100
   } mode_type;

   typedef enum logic [1:0] {
      PSTATE_IDLE = 2'd0,
      PSTATE_RECV = 2'd1,
      PSTATE_DONE = 2'd2
   } pstate_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_ILLEGAL = 2'd1,
      ERR_COUNT   = 2'd2,
      ERR_LENGTH  = 2'd3
   } err_type;

   function automatic pstate_type mode_code(mode_type m);
      pstate_type code;
      unique case (m)
         MODE_IDLE: code = PSTATE_IDLE;
         MODE_RECV: code = PSTATE_RECV;
         MODE_DONE: code = PSTATE_DONE;
         default:   code = PSTATE_IDLE;
      endcase
      return code;
   endfunction

endpackage

>>> hw/rtl/dmfp_store.sv
`timescale 1ns / 1ps
// Character and length stores of the parser, each one write and one registered read port.
// Depends on dmfp_pkg.
module dmfp_store
   import dmfp_pkg::*;
#(
   parameter int unsigned MAX_ITEMS      = DefMaxItems,
   parameter int unsigned MAX_ITEM_CHARS = DefMaxItemChars,
   localparam int unsigned Depth = MAX_ITEMS * MAX_ITEM_CHARS,
   localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int unsigned IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
   localparam int unsigned PW    = $clog2(MAX_ITEM_CHARS + 1)
) (
   input  logic          clock,
   input  logic          char_we,
   input  logic [AW-1:0] char_waddr,
   input  logic [7:0]    char_wdata,
   input  logic          len_we,
   input  logic [IW-1:0] len_waddr,
   input  logic [PW-1:0] len_wdata,
   input  logic          rd_en,
   input  logic [AW-1:0] char_raddr,
   input  logic [IW-1:0] len_raddr,
   output logic [7:0]    char_rdata,
   output logic [PW-1:0] len_rdata
);

   logic [7:0]    char_mem [Depth];
   logic [PW-1:0] len_mem  [MAX_ITEMS];
   logic [7:0]    char_rd_ff;
   logic [PW-1:0] len_rd_ff;

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[char_waddr] <= char_wdata;
      end
      if (rd_en) begin
         char_rd_ff <= char_mem[char_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (rd_en) begin
         len_rd_ff <= len_mem[len_raddr];
      end
   end

   assign char_rdata = char_rd_ff;
   assign len_rdata  = len_rd_ff;

endmodule

>>> hw/rtl/delimited_message_field_parser.sv
`timescale 1ns / 1ps
// Result path: a request word's result is registered in the read stage, then in the result register.
// Throughput: one request word per cycle; the store read and the result register
// form a two-deep pipeline, so a stalled result blocks requests only once both are full.
// Reset: mode idle, no error, no items, delimiters back to '[' ']' ','.
// Store contents are not cleared; only entries of the current message are ever read.
module delimited_message_field_parser
   import dmfp_pkg::*;
#(
   parameter int unsigned MAX_ITEMS      = DefMaxItems,
   parameter int unsigned MAX_ITEM_CHARS = DefMaxItemChars
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_rx_byte,
   input  logic [3:0] req_item_index,
   input  logic [4:0] req_char_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_parse_state,
   output logic [1:0] rsp_error_code,
   output logic [4:0] rsp_item_count,
   output logic [7:0] rsp_read_char,
   output logic [5:0] rsp_read_length,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int unsigned Depth = MAX_ITEMS * MAX_ITEM_CHARS;
   localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
   localparam int unsigned PW    = $clog2(MAX_ITEM_CHARS + 1);

   logic [7:0] start_ff, stop_ff, sep_ff;

   mode_type      mode_ff, mode_in;
   err_type       err_ff, err_in;
   logic [CW-1:0] items_ff, items_in;
   logic [PW-1:0] pos_ff, pos_in;

   logic          accept;
   logic          s1_adv;
   logic          s1_valid_ff, s1_valid_in;
   pstate_type    s1_state_ff;
   err_type       s1_err_ff;
   logic [4:0]    s1_count_ff;
   logic          s1_rd_ok_ff;
   logic [4:0]    s1_pos_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_state_ff;
   logic [1:0]    rsp_err_ff;
   logic [4:0]    rsp_count_ff;
   logic [7:0]    rsp_char_ff;
   logic [5:0]    rsp_len_ff;

   logic          char_we, len_we;
   logic [AW-1:0] char_waddr, char_raddr;
   logic [IW-1:0] len_waddr, len_raddr;
   logic [7:0]    char_rdata;
   logic [PW-1:0] len_rdata;
   logic          rd_ok;
   logic          blank;
   logic [7:0]    s1_char;
   logic [5:0]    s1_len;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= StartCharReset;
         stop_ff  <= StopCharReset;
         sep_ff   <= SepCharReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START: start_ff <= csr_wdata;
            CSR_STOP:  stop_ff  <= csr_wdata;
            CSR_SEP:   sep_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   // parser next state
   assign blank = (req_rx_byte == CharNewline) || (req_rx_byte == CharSpace);

   always_comb begin
      mode_in  = mode_ff;
      err_in   = err_ff;
      items_in = items_ff;
      pos_in   = pos_ff;
      char_we  = 1'b0;
      len_we   = 1'b0;
      if (accept) begin
         unique case (req_cmd)
            CMD_PUSH: begin
               if (req_rx_byte != CharNull) begin
                  unique case (mode_ff)
                     MODE_IDLE: begin
                        if (req_rx_byte == start_ff) begin
                           items_in = '0;
                           pos_in   = '0;
                           mode_in  = MODE_RECV;
                           err_in   = ERR_NONE;
                        end else if (!blank) begin
                           items_in = '0;
                           pos_in   = '0;
                           err_in   = ERR_ILLEGAL;
                        end
                     end
                     MODE_RECV: begin
                        priority if (req_rx_byte == start_ff) begin
                           items_in = '0;
                           pos_in   = '0;
                           mode_in  = MODE_IDLE;
                           err_in   = ERR_ILLEGAL;
                        end else if (req_rx_byte == stop_ff) begin
                           if (pos_ff != '0) begin
                              if (32'(items_ff) < MAX_ITEMS) begin
                                 len_we   = 1'b1;
                                 items_in = items_ff + CW'(1);
                              end
                              pos_in = '0;
                           end
                           mode_in = MODE_DONE;
                        end else if (req_rx_byte == sep_ff) begin
                           priority if (pos_ff == '0) begin
                              items_in = '0;
                              mode_in  = MODE_IDLE;
                              err_in   = ERR_LENGTH;
                           end else if (32'(items_ff) >= MAX_ITEMS) begin
                              items_in = '0;
                              pos_in   = '0;
                              mode_in  = MODE_IDLE;
                              err_in   = ERR_COUNT;
                           end else begin
                              len_we   = 1'b1;
                              items_in = items_ff + CW'(1);
                              pos_in   = '0;
                           end
                        end else if (32'(pos_ff) >= MAX_ITEM_CHARS) begin
                           items_in = '0;
                           pos_in   = '0;
                           mode_in  = MODE_IDLE;
                           err_in   = ERR_LENGTH;
                        end else if (!blank) begin
                           if (32'(items_ff) >= MAX_ITEMS) begin
                              items_in = '0;
                              pos_in   = '0;
                              mode_in  = MODE_IDLE;
                              err_in   = ERR_COUNT;
                           end else begin
                              char_we = 1'b1;
                              pos_in  = pos_ff + PW'(1);
                           end
                        end
                     end
                     MODE_DONE: ;
                     default: ;
                  endcase
               end
            end
            CMD_CLEAR: begin
               items_in = '0;
               pos_in   = '0;
               mode_in  = MODE_IDLE;
               err_in   = ERR_NONE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         err_ff   <= ERR_NONE;
         items_ff <= '0;
         pos_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         err_ff   <= err_in;
         items_ff <= items_in;
         pos_ff   <= pos_in;
      end
   end

   // store access: writes and reads come from different words, so a read
   // always sees the write of the word before it
   assign rd_ok = (req_cmd == CMD_READ) && (mode_ff == MODE_DONE)
                  && (32'(req_item_index) < 32'(items_ff))
                  && (32'(req_item_index) < MAX_ITEMS);

   assign char_waddr = AW'(32'(items_ff) * MAX_ITEM_CHARS + 32'(pos_ff));
   assign len_waddr  = items_ff[IW-1:0];
   assign char_raddr = (rd_ok && (32'(req_char_index) < MAX_ITEM_CHARS))
                       ? AW'(32'(req_item_index) * MAX_ITEM_CHARS + 32'(req_char_index))
                       : '0;
   assign len_raddr  = rd_ok ? IW'(req_item_index) : '0;

   dmfp_store #(
      .MAX_ITEMS      (MAX_ITEMS),
      .MAX_ITEM_CHARS (MAX_ITEM_CHARS)
   ) u_store (
      .clock      (clock),
      .char_we    (char_we),
      .char_waddr (char_waddr),
      .char_wdata (req_rx_byte),
      .len_we     (len_we),
      .len_waddr  (len_waddr),
      .len_wdata  (pos_ff),
      .rd_en      (accept),
      .char_raddr (char_raddr),
      .len_raddr  (len_raddr),
      .char_rdata (char_rdata),
      .len_rdata  (len_rdata)
   );

   // read stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_state_ff <= mode_code(mode_in);
         s1_err_ff   <= err_in;
         s1_count_ff <= (mode_in == MODE_DONE) ? 5'(items_in) : 5'd0;
         s1_rd_ok_ff <= rd_ok;
         s1_pos_ff   <= req_char_index;
      end
   end

   assign s1_len  = s1_rd_ok_ff ? 6'(len_rdata) : 6'd0;
   assign s1_char = (s1_rd_ok_ff && (32'(s1_pos_ff) < 32'(len_rdata))
                     && (32'(s1_pos_ff) < MAX_ITEM_CHARS)) ? char_rdata : 8'd0;

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         rsp_state_ff <= s1_state_ff;
         rsp_err_ff   <= s1_err_ff;
         rsp_count_ff <= s1_count_ff;
         rsp_char_ff  <= s1_char;
         rsp_len_ff   <= s1_len;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_parse_state = rsp_state_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_item_count  = rsp_count_ff;
   assign rsp_read_char   = rsp_char_ff;
   assign rsp_read_length = rsp_len_ff;

`ifndef SYNTHESIS
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free pipeline slot");

   a_items_bound: assert property (@(posedge clock) disable iff (reset)
      32'(items_ff) <= MAX_ITEMS)
      else $error("stored item count beyond limit");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (items_ff == '0 && pos_ff == '0))
      else $error("idle parser holds items");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word lost before read stage");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for delimited_message_field_parser: directed framing cases, capacity limits,
// randomised message traffic under several delimiter settings, back-pressure and full rate.
// Depends on dmfp_pkg and the parser RTL; predicts every result word and checks it field by field.
module tb
   import dmfp_pkg::*;
;

   localparam int unsigned MaxItems       = DefMaxItems;
   localparam int unsigned MaxChars       = DefMaxItemChars;
   localparam int unsigned LongHoldCycles = 200;
   localparam logic [1:0]  CmdUnused      = 2'd3;

   typedef struct packed {
      pstate_type state;
      err_type    err;
      logic [4:0] count;
      logic [7:0] ch;
      logic [5:0] len;
   } parser_status_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd        = '0;
   logic [7:0] req_rx_byte    = '0;
   logic [3:0] req_item_index = '0;
   logic [4:0] req_char_index = '0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [1:0] rsp_parse_state;
   logic [1:0] rsp_error_code;
   logic [4:0] rsp_item_count;
   logic [7:0] rsp_read_char;
   logic [5:0] rsp_read_length;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index      = '0;
   logic [7:0] csr_wdata      = '0;

   // predictor state
   logic [7:0] start_reg = StartCharReset;
   logic [7:0] stop_reg  = StopCharReset;
   logic [7:0] sep_reg   = SepCharReset;
   pstate_type parse_mode  = PSTATE_IDLE;
   err_type    parse_error = ERR_NONE;
   logic [4:0] items_held  = '0;
   logic [5:0] char_pos    = '0;
   logic [7:0] char_mem [MaxItems * MaxChars];
   logic [5:0] field_len [MaxItems];

   parser_status_type expected_status [$];
   parser_status_type want;
   int  sent_count     = 0;
   int  checked_count  = 0;
   int  mismatch_count = 0;
   bit  req_gaps_on    = 1'b1;
   bit  rsp_stalls_on  = 1'b1;
   bit  hold_request   = 1'b0;

   delimited_message_field_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_rx_byte     (req_rx_byte),
      .req_item_index  (req_item_index),
      .req_char_index  (req_char_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_parse_state (rsp_parse_state),
      .rsp_error_code  (rsp_error_code),
      .rsp_item_count  (rsp_item_count),
      .rsp_read_char   (rsp_read_char),
      .rsp_read_length (rsp_read_length),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void abort_message(err_type e);
      items_held  = '0;
      char_pos    = '0;
      parse_mode  = PSTATE_IDLE;
      parse_error = e;
   endfunction

   function automatic void close_field();
      if (items_held < MaxItems) begin
         field_len[items_held] = char_pos;
         items_held++;
      end
      char_pos = '0;
   endfunction

   function automatic void take_rx(logic [7:0] b);
      logic blank;
      blank = (b == CharNewline) || (b == CharSpace);
      if (b == CharNull) return;
      case (parse_mode)
         PSTATE_IDLE: begin
            if (b == start_reg) begin
               items_held  = '0;
               char_pos    = '0;
               parse_mode  = PSTATE_RECV;
               parse_error = ERR_NONE;
            end else if (!blank) begin
               abort_message(ERR_ILLEGAL);
            end
         end
         PSTATE_RECV: begin
            if (b == start_reg) begin
               abort_message(ERR_ILLEGAL);
            end else if (b == stop_reg) begin
               if (char_pos != 0) close_field();
               parse_mode = PSTATE_DONE;
            end else if (b == sep_reg) begin
               if (char_pos == 0) abort_message(ERR_LENGTH);
               else if (items_held >= MaxItems) abort_message(ERR_COUNT);
               else close_field();
            end else if (char_pos >= MaxChars) begin
               abort_message(ERR_LENGTH);
            end else if (!blank) begin
               if (items_held >= MaxItems) begin
                  abort_message(ERR_COUNT);
               end else begin
                  char_mem[int'(items_held) * MaxChars + int'(char_pos)] = b;
                  char_pos++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic parser_status_type predict_status(logic [1:0] cmd, logic [7:0] rx,
                                                        logic [3:0] item, logic [4:0] pos);
      parser_status_type st;
      st = '0;
      case (cmd)
         CMD_PUSH: take_rx(rx);
         CMD_READ: begin
            if (parse_mode == PSTATE_DONE && item < items_held) begin
               st.len = field_len[item];
               if (pos < field_len[item]) st.ch = char_mem[int'(item) * MaxChars + int'(pos)];
            end
         end
         CMD_CLEAR: abort_message(ERR_NONE);
         default: ;
      endcase
      st.state = parse_mode;
      st.err   = parse_error;
      st.count = (parse_mode == PSTATE_DONE) ? items_held : '0;
      return st;
   endfunction

   task automatic report_mismatch(string what, int got, int want_v);
      $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want_v);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            report_mismatch("word with nothing expected, parse_state", rsp_parse_state, -1);
         end else begin
            want = expected_status.pop_front();
            if (rsp_parse_state != want.state)
               report_mismatch("parse_state", rsp_parse_state, want.state);
            if (rsp_error_code != want.err)
               report_mismatch("error_code", rsp_error_code, want.err);
            if (rsp_item_count != want.count)
               report_mismatch("item_count", rsp_item_count, want.count);
            if (rsp_read_char != want.ch)
               report_mismatch("read_char", rsp_read_char, want.ch);
            if (rsp_read_length != want.len)
               report_mismatch("read_length", rsp_read_length, want.len);
         end
         checked_count++;
      end
   end

   always begin
      @(posedge clock);
      if (hold_request) begin
         hold_request = 1'b0;
         rsp_stall <= 1'b1;
         repeat (LongHoldCycles) @(posedge clock);
         rsp_stall <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(logic [1:0] cmd, logic [7:0] rx, logic [3:0] item, logic [4:0] pos);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_rx_byte    <= rx;
      req_item_index <= item;
      req_char_index <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_status.push_back(predict_status(cmd, rx, item, pos));
      sent_count++;
   endtask

   task automatic push_byte(logic [7:0] b);
      send_word(CMD_PUSH, b, 4'($urandom), 5'($urandom));
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic read_char_at(logic [3:0] item, logic [4:0] pos);
      send_word(CMD_READ, 8'($urandom), item, pos);
   endtask

   task automatic clear_parser();
      send_word(CMD_CLEAR, 8'($urandom), 4'($urandom), 5'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (checked_count != sent_count);
   endtask

   task automatic write_register(csr_index_type idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_START: start_reg = value;
         CSR_STOP:  stop_reg  = value;
         CSR_SEP:   sep_reg   = value;
         default: ;
      endcase
   endtask

   task automatic set_delimiters(logic [7:0] start_c, logic [7:0] stop_c, logic [7:0] sep_c);
      wait_drained();
      write_register(CSR_START, start_c);
      write_register(CSR_STOP, stop_c);
      write_register(CSR_SEP, sep_c);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_item_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == CharNewline || c == CharSpace || c == start_reg || c == stop_reg
             || c == sep_reg);
      return c;
   endfunction

   function automatic logic [7:0] pick_filler();
      case ($urandom_range(0, 2))
         0: return CharNull;
         1: return CharNewline;
         default: return CharSpace;
      endcase
   endfunction

   task automatic send_message(int n_fields, int len_lo, int len_hi, bit trailing_sep,
                               bit closed);
      int len;
      push_byte(start_reg);
      for (int f = 0; f < n_fields; f++) begin
         len = $urandom_range(len_lo, len_hi);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) push_byte(pick_filler());
            push_byte(pick_item_char());
         end
         if (f < n_fields - 1 || trailing_sep) push_byte(sep_reg);
      end
      if ($urandom_range(0, 19) == 0) push_byte(start_reg);
      if (closed) push_byte(stop_reg);
   endtask

   task automatic read_back(int n_reads, int n_fields);
      int top;
      top = (n_fields > MaxItems) ? MaxItems - 1 : ((n_fields > 0) ? n_fields - 1 : 0);
      repeat (n_reads) begin
         if ($urandom_range(0, 3) == 0)
            read_char_at(4'($urandom), 5'($urandom));
         else
            read_char_at(4'($urandom_range(0, top)), 5'($urandom_range(0, 6)));
      end
   endtask

   task automatic test_directed_cases();
      send_word(CmdUnused, 8'hFF, 4'hF, 5'h1F);
      read_char_at(4'd0, 5'd0);
      push_byte(CharNull);
      push_text("\n x");
      push_text("[ [");
      push_text("[,");
      push_text("[]");
      read_char_at(4'd0, 5'd0);
      push_text("a");
      clear_parser();
      push_text("[a");
      push_byte(8'hFF);
      push_text(",");
      push_byte(8'h01);
      push_text(",]");
      read_char_at(4'd0, 5'd1);
      read_char_at(4'd1, 5'd0);
      read_char_at(4'd1, 5'd1);
      read_char_at(4'd2, 5'd0);
      read_char_at(4'd15, 5'd31);
      clear_parser();
   endtask

   task automatic test_capacity_limits();
      send_message(MaxItems, 1, 3, 1'b0, 1'b1);
      read_back(6, MaxItems);
      read_char_at(4'(MaxItems - 1), 5'd0);
      clear_parser();
      send_message(1, MaxChars, MaxChars, 1'b0, 1'b1);
      read_char_at(4'd0, 5'(MaxChars - 1));
      read_char_at(4'd0, 5'd0);
      clear_parser();
      send_message(1, MaxChars + 1, MaxChars + 1, 1'b0, 1'b1);
      send_message(MaxItems + 1, 1, 2, 1'b0, 1'b1);
      clear_parser();
      wait_drained();
   endtask

   task automatic test_random_traffic(int budget, bit with_idling);
      int stop_at;
      int n_fields;
      int len_lo;
      int len_hi;
      stop_at = sent_count + budget;
      while (sent_count < stop_at) begin
         if (with_idling) begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6))
               send_word(2'($urandom), 8'($urandom), 4'($urandom), 5'($urandom));
         end else begin
            n_fields = ($urandom_range(0, 19) == 0) ? $urandom_range(MaxItems - 1, MaxItems + 1)
                                                    : $urandom_range(0, 4);
            len_lo   = ($urandom_range(0, 19) == 0) ? 0 : 1;
            len_hi   = ($urandom_range(0, 19) == 0) ? $urandom_range(MaxChars - 1, MaxChars + 1)
                                                    : $urandom_range(1, 5);
            send_message(n_fields, len_lo, len_hi, $urandom_range(0, 7) == 0,
                         $urandom_range(0, 9) != 0);
            read_back($urandom_range(0, 6), n_fields);
            if ($urandom_range(0, 5) == 0) push_byte(8'($urandom));
            if ($urandom_range(0, 3) != 0) clear_parser();
         end
      end
   endtask

   task automatic test_backpressure();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      hold_request  = 1'b1;
      send_message(3, 2, 4, 1'b0, 1'b1);
      read_back(12, 3);
      clear_parser();
      wait_drained();
   endtask

   task automatic test_delimiter_settings();
      set_delimiters(8'hFF, 8'hFE, CharNull);
      test_random_traffic(120, 1'b1);
      set_delimiters(CharNull, CharNull, CharNull);
      test_random_traffic(40, 1'b1);
      set_delimiters(CharNewline, CharSpace, 8'h7C);
      test_random_traffic(120, 1'b1);
      set_delimiters(8'h78, 8'h78, 8'h78);
      test_random_traffic(60, 1'b1);
   endtask

   task automatic test_full_rate();
      set_delimiters(8'h3C, 8'h3E, 8'h7C);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      test_random_traffic(100, 1'b0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_capacity_limits();
      test_random_traffic(450, 1'b1);
      test_backpressure();
      test_delimiter_settings();
      test_full_rate();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> delimited_message_field_parser.f
hw/rtl/dmfp_pkg.sv
hw/rtl/dmfp_store.sv
hw/rtl/delimited_message_field_parser.sv
dv/tb.sv
